FILE: hdl/tun_pkg.sv
// Shared widths, types and constants for the triangle unit normal core.
`timescale 1ns / 1ps
`default_nettype none

package tun_pkg;

    localparam int CoordW = 32;              // Q16.16 vertex coordinate
    localparam int EdgeW  = CoordW + 1;      // exact edge difference
    localparam int ProdW  = 2 * EdgeW;       // edge component product
    localparam int CrossW = ProdW + 1;       // exact cross component
    localparam int LenW   = 7;               // bit length of a cross magnitude
    localparam int ScaleW = 31;              // normalized magnitude
    localparam int SqW    = 2 * ScaleW;      // square of a normalized magnitude
    localparam int SumW   = 64;              // sum of three squares
    localparam int RootW  = SumW / 2;        // integer square root
    localparam int RemW   = RootW + 3;       // square root partial remainder
    localparam int FracW  = 30;              // Q2.30 fraction bits
    localparam int NumW   = ScaleW + FracW + 1; // rounded dividend
    localparam int QuotW  = ScaleW;          // quotient, at most 2^30
    localparam int DRemW  = RootW;           // divider partial remainder
    localparam int OutW   = 32;              // Q2.30 output component

    localparam logic [LenW-1:0] ScaleLen = LenW'(ScaleW);

    typedef logic [2:0][CoordW-1:0] t_vec;

    // Normalized magnitudes with their signs, travelling beside the root.
    typedef struct packed {
        logic [2:0][ScaleW-1:0] s;
        logic [2:0]             neg;
        logic                   degen;
    } t_side;

    // Sign and degenerate flag, travelling beside the quotients.
    typedef struct packed {
        logic [2:0] neg;
        logic       degen;
    } t_sign;

endpackage

`default_nettype wire

FILE: hdl/triangle_unit_normal_core.sv
// Top level of the triangle unit normal core.
`timescale 1ns / 1ps
`default_nettype none

// Takes one triangle (vertices a, b, c in signed Q16.16) per clock unless stalled and
// returns the unit normal of (b - a) x (c - b), or its reverse when clockwise is set,
// in signed Q2.30, with degenerate raised and a zero normal when the cross product
// vanishes. Throughput is one triangle per cycle while not stalled. There are 8 front
// stages (edges, 33x33 multiplies, cross subtract, magnitude, length, shift, squares,
// sum), 32 square-root stages, one dividend stage, 31 divider stages and the output
// register. A result-side stall with a result held freezes the whole pipeline and
// goes upstream as o_stall in the same cycle. The clockwise register is always ready.

module triangle_unit_normal_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_data,

    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [31:0] i_ax,
    input  wire logic [31:0] i_ay,
    input  wire logic [31:0] i_az,
    input  wire logic [31:0] i_bx,
    input  wire logic [31:0] i_by,
    input  wire logic [31:0] i_bz,
    input  wire logic [31:0] i_cx,
    input  wire logic [31:0] i_cy,
    input  wire logic [31:0] i_cz,

    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [31:0]      o_normal_x,
    output logic [31:0]      o_normal_y,
    output logic [31:0]      o_normal_z,
    output logic             o_degenerate
);

    logic                               r_cw;
    logic                               w_en;
    tun_pkg::t_vec                      w_a, w_b, w_c;

    logic                               w_f_valid;
    logic [tun_pkg::SumW-1:0]           w_f_sum;
    tun_pkg::t_side                     w_f_side;

    logic                               w_s_valid;
    logic [tun_pkg::RootW-1:0]          w_s_root;
    tun_pkg::t_side                     w_s_side;

    logic                               w_d_valid;
    logic [2:0][tun_pkg::QuotW-1:0]     w_d_quot;
    tun_pkg::t_sign                     w_d_sign;

    logic                               r_out_v;
    logic [2:0][tun_pkg::OutW-1:0]      r_out;
    logic                               r_out_degen;
    logic [2:0][tun_pkg::OutW-1:0]      n_out;

    // advance whenever the output slot is empty or being taken
    assign w_en        = !r_out_v || !i_stall;
    assign o_stall     = !w_en;
    assign o_cfg_ready = 1'b1;

    assign w_a = {i_az, i_ay, i_ax};
    assign w_b = {i_bz, i_by, i_bx};
    assign w_c = {i_cz, i_cy, i_cx};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cw <= 1'b0;
        end else if (i_cfg_valid) begin
            r_cw <= i_cfg_data;
        end
    end

    tun_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_cw    (r_cw),
        .i_a     (w_a),
        .i_b     (w_b),
        .i_c     (w_c),
        .o_valid (w_f_valid),
        .o_sum   (w_f_sum),
        .o_side  (w_f_side)
    );

    tun_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_f_valid),
        .i_sum   (w_f_sum),
        .i_side  (w_f_side),
        .o_valid (w_s_valid),
        .o_root  (w_s_root),
        .o_side  (w_s_side)
    );

    tun_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_s_valid),
        .i_mag   (w_s_root),
        .i_side  (w_s_side),
        .o_valid (w_d_valid),
        .o_quot  (w_d_quot),
        .o_sign  (w_d_sign)
    );

    // restore the sign; drop to zero for a degenerate triangle
    always_comb begin
        logic [tun_pkg::OutW-1:0] m;
        for (int i = 0; i < 3; i++) begin
            m = {{(tun_pkg::OutW - tun_pkg::QuotW){1'b0}}, w_d_quot[i]};
            if (w_d_sign.degen)    n_out[i] = '0;
            else if (w_d_sign.neg[i]) n_out[i] = ~m + 1'b1;
            else                   n_out[i] = m;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_en) begin
            r_out_v <= w_d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out       <= n_out;
            r_out_degen <= w_d_sign.degen;
        end
    end

    assign o_valid      = r_out_v;
    assign o_normal_x   = r_out[0];
    assign o_normal_y   = r_out[1];
    assign o_normal_z   = r_out[2];
    assign o_degenerate = r_out_degen;

endmodule

`default_nettype wire

FILE: hdl/tun_front.sv
// Front stages: edges, cross product, magnitude, normalizing shift, squares and sum.
`timescale 1ns / 1ps
`default_nettype none

module tun_front (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_en,
    input  wire logic                  i_valid,
    input  wire logic                  i_cw,
    input  wire tun_pkg::t_vec         i_a,
    input  wire tun_pkg::t_vec         i_b,
    input  wire tun_pkg::t_vec         i_c,
    output logic                       o_valid,
    output logic [tun_pkg::SumW-1:0]   o_sum,
    output tun_pkg::t_side             o_side
);

    function automatic logic [tun_pkg::ProdW-1:0] smul(
        input logic [tun_pkg::EdgeW-1:0] x,
        input logic [tun_pkg::EdgeW-1:0] y
    );
        logic signed [tun_pkg::ProdW-1:0] r;
        r = $signed(x) * $signed(y);
        return r;
    endfunction

    function automatic logic [tun_pkg::LenW-1:0] bitlen(
        input logic [tun_pkg::CrossW-1:0] x
    );
        logic [tun_pkg::LenW-1:0] r;
        r = '0;
        for (int i = 0; i < tun_pkg::CrossW; i++) begin
            if (x[i]) r = tun_pkg::LenW'(i + 1);
        end
        return r;
    endfunction

    logic [7:0] r_v;

    logic [2:0][tun_pkg::EdgeW-1:0]  n_u, n_v;
    logic [2:0][tun_pkg::EdgeW-1:0]  r_p, r_q;
    logic [5:0][tun_pkg::ProdW-1:0]  r_m;
    logic [2:0][tun_pkg::CrossW-1:0] r_cp;
    logic [2:0][tun_pkg::CrossW-1:0] r_mag, r_mag2;
    logic [2:0]                      r_neg, r_neg2;
    logic [tun_pkg::LenW-1:0]        r_len;
    tun_pkg::t_side                  n_side, r_side, r_side2, r_side3;
    logic [2:0][tun_pkg::SqW-1:0]    r_sq;
    logic [tun_pkg::SumW-1:0]        r_sum;
    logic [tun_pkg::LenW-1:0]        w_shr, w_shl;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_u[i] = {i_b[i][tun_pkg::CoordW-1], i_b[i]} - {i_a[i][tun_pkg::CoordW-1], i_a[i]};
            n_v[i] = {i_c[i][tun_pkg::CoordW-1], i_c[i]} - {i_b[i][tun_pkg::CoordW-1], i_b[i]};
        end
    end

    assign w_shr = r_len - tun_pkg::ScaleLen;
    assign w_shl = tun_pkg::ScaleLen - r_len;

    always_comb begin
        logic [tun_pkg::CrossW-1:0] t;
        n_side = '0;
        for (int i = 0; i < 3; i++) begin
            if (r_len > tun_pkg::ScaleLen) t = r_mag2[i] >> w_shr;
            else                           t = r_mag2[i] << w_shl;
            n_side.s[i] = t[tun_pkg::ScaleW-1:0];
        end
        n_side.neg   = r_neg2;
        n_side.degen = (r_len == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[6:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // swap operands for clockwise winding
            r_p <= i_cw ? n_v : n_u;
            r_q <= i_cw ? n_u : n_v;

            r_m[0] <= smul(r_p[1], r_q[2]);
            r_m[1] <= smul(r_p[2], r_q[1]);
            r_m[2] <= smul(r_p[2], r_q[0]);
            r_m[3] <= smul(r_p[0], r_q[2]);
            r_m[4] <= smul(r_p[0], r_q[1]);
            r_m[5] <= smul(r_p[1], r_q[0]);

            for (int i = 0; i < 3; i++) begin
                r_cp[i] <= {r_m[2*i][tun_pkg::ProdW-1], r_m[2*i]}
                         - {r_m[2*i+1][tun_pkg::ProdW-1], r_m[2*i+1]};
                r_neg[i] <= r_cp[i][tun_pkg::CrossW-1];
                r_mag[i] <= r_cp[i][tun_pkg::CrossW-1] ? (~r_cp[i] + 1'b1) : r_cp[i];
            end

            // the OR of the magnitudes has the bit length of the largest
            r_len  <= bitlen(r_mag[0] | r_mag[1] | r_mag[2]);
            r_mag2 <= r_mag;
            r_neg2 <= r_neg;

            r_side <= n_side;

            for (int i = 0; i < 3; i++) begin
                r_sq[i] <= {{tun_pkg::ScaleW{1'b0}}, r_side.s[i]}
                         * {{tun_pkg::ScaleW{1'b0}}, r_side.s[i]};
            end
            r_side2 <= r_side;

            r_sum   <= {2'b00, r_sq[0]} + {2'b00, r_sq[1]} + {2'b00, r_sq[2]};
            r_side3 <= r_side2;
        end
    end

    assign o_valid = r_v[7];
    assign o_sum   = r_sum;
    assign o_side  = r_side3;

endmodule

`default_nettype wire

FILE: hdl/tun_sqrt.sv
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps
`default_nettype none

module tun_sqrt (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_en,
    input  wire logic                  i_valid,
    input  wire logic [tun_pkg::SumW-1:0] i_sum,
    input  wire tun_pkg::t_side        i_side,
    output logic                       o_valid,
    output logic [tun_pkg::RootW-1:0]  o_root,
    output tun_pkg::t_side             o_side
);

    localparam int Stages = tun_pkg::RootW;

    logic                       r_v    [Stages];
    logic [tun_pkg::RemW-1:0]   r_rem  [Stages];
    logic [tun_pkg::RootW-1:0]  r_root [Stages];
    logic [tun_pkg::SumW-1:0]   r_x    [Stages];
    tun_pkg::t_side             r_side [Stages];

    for (genvar k = 0; k < Stages; k++) begin : g_stage
        logic                      w_vi;
        logic [tun_pkg::RemW-1:0]  w_ri, w_sh, w_tr;
        logic [tun_pkg::RootW-1:0] w_qi;
        logic [tun_pkg::SumW-1:0]  w_xi;
        tun_pkg::t_side            w_si;
        logic                      w_ge;

        if (k == 0) begin : g_first
            assign w_vi = i_valid;
            assign w_ri = '0;
            assign w_qi = '0;
            assign w_xi = i_sum;
            assign w_si = i_side;
        end else begin : g_next
            assign w_vi = r_v[k-1];
            assign w_ri = r_rem[k-1];
            assign w_qi = r_root[k-1];
            assign w_xi = r_x[k-1];
            assign w_si = r_side[k-1];
        end

        // bring down the next two radicand bits, try root*4+1
        assign w_sh = {w_ri[tun_pkg::RemW-3:0], w_xi[tun_pkg::SumW-1 -: 2]};
        assign w_tr = {1'b0, w_qi, 2'b01};
        assign w_ge = (w_sh >= w_tr);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= w_vi;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= w_ge ? (w_sh - w_tr) : w_sh;
                r_root[k] <= {w_qi[tun_pkg::RootW-2:0], w_ge};
                r_x[k]    <= {w_xi[tun_pkg::SumW-3:0], 2'b00};
                r_side[k] <= w_si;
            end
        end
    end

    assign o_valid = r_v[Stages-1];
    assign o_root  = r_root[Stages-1];
    assign o_side  = r_side[Stages-1];

endmodule

`default_nettype wire

FILE: hdl/tun_div.sv
// Pipelined three-lane restoring divider: rounded magnitude over root, one bit per stage.
`timescale 1ns / 1ps
`default_nettype none

module tun_div (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_en,
    input  wire logic                         i_valid,
    input  wire logic [tun_pkg::RootW-1:0]    i_mag,
    input  wire tun_pkg::t_side               i_side,
    output logic                              o_valid,
    output logic [2:0][tun_pkg::QuotW-1:0]    o_quot,
    output tun_pkg::t_sign                    o_sign
);

    localparam int Stages = tun_pkg::QuotW;
    localparam int LowW   = tun_pkg::NumW - tun_pkg::QuotW;

    logic                                 r_pv;
    logic [2:0][tun_pkg::DRemW-1:0]       r_prem;
    logic [2:0][LowW-1:0]                 r_plow;
    logic [tun_pkg::RootW-1:0]            r_pmag;
    tun_pkg::t_sign                       r_psign;
    logic [2:0][tun_pkg::NumW-1:0]        n_num;

    logic                                 r_v    [Stages];
    logic [2:0][tun_pkg::DRemW-1:0]       r_rem  [Stages];
    logic [2:0][LowW-1:0]                 r_low  [Stages];
    logic [2:0][tun_pkg::QuotW-1:0]       r_q    [Stages];
    logic [tun_pkg::RootW-1:0]            r_mag  [Stages];
    tun_pkg::t_sign                       r_sign [Stages];

    // dividend s * 2^30 + floor(mag / 2)
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_num[i] = {1'b0, i_side.s[i], {tun_pkg::FracW{1'b0}}}
                     + {{(tun_pkg::NumW - tun_pkg::RootW + 1){1'b0}},
                        i_mag[tun_pkg::RootW-1:1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else if (i_en) begin
            r_pv <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_prem[i] <= {1'b0, n_num[i][tun_pkg::NumW-1:LowW]};
                r_plow[i] <= n_num[i][LowW-1:0];
            end
            r_pmag        <= i_mag;
            r_psign.neg   <= i_side.neg;
            r_psign.degen <= i_side.degen;
        end
    end

    for (genvar k = 0; k < Stages; k++) begin : g_stage
        logic                            w_vi;
        logic [2:0][tun_pkg::DRemW-1:0]  w_ri;
        logic [2:0][LowW-1:0]            w_li;
        logic [2:0][tun_pkg::QuotW-1:0]  w_qi;
        logic [tun_pkg::RootW-1:0]       w_mi;
        tun_pkg::t_sign                  w_si;
        logic [2:0][tun_pkg::DRemW-1:0]  n_rem;
        logic [2:0][LowW-1:0]            n_low;
        logic [2:0][tun_pkg::QuotW-1:0]  n_q;

        if (k == 0) begin : g_first
            assign w_vi = r_pv;
            assign w_ri = r_prem;
            assign w_li = r_plow;
            assign w_qi = '0;
            assign w_mi = r_pmag;
            assign w_si = r_psign;
        end else begin : g_next
            assign w_vi = r_v[k-1];
            assign w_ri = r_rem[k-1];
            assign w_li = r_low[k-1];
            assign w_qi = r_q[k-1];
            assign w_mi = r_mag[k-1];
            assign w_si = r_sign[k-1];
        end

        always_comb begin
            logic [tun_pkg::DRemW:0] t;
            logic [tun_pkg::DRemW:0] d;
            logic                    ge;
            for (int i = 0; i < 3; i++) begin
                t  = {w_ri[i], w_li[i][LowW-1]};
                d  = t - {1'b0, w_mi};
                ge = (t >= {1'b0, w_mi});
                n_rem[i] = ge ? d[tun_pkg::DRemW-1:0] : t[tun_pkg::DRemW-1:0];
                n_low[i] = {w_li[i][LowW-2:0], 1'b0};
                n_q[i]   = {w_qi[i][tun_pkg::QuotW-2:0], ge};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= w_vi;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_low[k]  <= n_low;
                r_q[k]    <= n_q;
                r_mag[k]  <= w_mi;
                r_sign[k] <= w_si;
            end
        end
    end

    assign o_valid = r_v[Stages-1];
    assign o_quot  = r_q[Stages-1];
    assign o_sign  = r_sign[Stages-1];

endmodule

`default_nettype wire

FILE: bench/tb_triangle_unit_normal_core.sv
// Self-checking testbench for the triangle unit normal core.
`timescale 1ns / 1ps

module tb_triangle_unit_normal_core;

    localparam int CycleLimit = 200000;
    localparam int DrainWait  = 100;

    typedef logic [tun_pkg::CoordW-1:0] t_tri [9];

    typedef struct {
        logic [tun_pkg::OutW-1:0] x;
        logic [tun_pkg::OutW-1:0] y;
        logic [tun_pkg::OutW-1:0] z;
        logic                     degen;
    } t_normal;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic i_cfg_data;
    logic i_valid;
    logic o_stall;
    logic [31:0] i_ax, i_ay, i_az, i_bx, i_by, i_bz, i_cx, i_cy, i_cz;
    logic o_valid;
    logic i_stall;
    logic [31:0] o_normal_x, o_normal_y, o_normal_z;
    logic o_degenerate;

    t_normal normal_q[$];
    bit      winding_cw;
    int      mismatch_cnt;
    int      cycle_cnt;
    bit      tx_no_gaps;
    bit      rx_no_stalls;
    bit      long_hold;

    triangle_unit_normal_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_ax(i_ax), .i_ay(i_ay), .i_az(i_az),
        .i_bx(i_bx), .i_by(i_by), .i_bz(i_bz),
        .i_cx(i_cx), .i_cy(i_cy), .i_cz(i_cz),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_normal_x(o_normal_x), .o_normal_y(o_normal_y), .o_normal_z(o_normal_z),
        .o_degenerate(o_degenerate)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic logic [63:0] isqrt(input logic [63:0] x);
        logic [63:0] res, one;
        res = 0;
        one = 64'd1 << 62;
        while (one > x) one = one >> 2;
        while (one != 0) begin
            if (x >= res + one) begin
                x   = x - (res + one);
                res = (res >> 1) + one;
            end else begin
                res = res >> 1;
            end
            one = one >> 2;
        end
        return res;
    endfunction

    // Exact cross product, then scale the largest magnitude to 31 bits and divide by the root.
    function automatic t_normal unit_normal(input t_tri t, input bit cw);
        logic signed [67:0] u [3], w [3], p [3], q [3], cr [3];
        logic [67:0] m [3];
        logic [30:0] s [3];
        logic [63:0] sum, root, qv;
        int len, k, i;
        t_normal r;
        for (i = 0; i < 3; i++) begin
            u[i] = $signed(t[3+i]) - $signed(t[i]);
            w[i] = $signed(t[6+i]) - $signed(t[3+i]);
        end
        for (i = 0; i < 3; i++) begin
            p[i] = cw ? w[i] : u[i];
            q[i] = cw ? u[i] : w[i];
        end
        cr[0] = p[1] * q[2] - p[2] * q[1];
        cr[1] = p[2] * q[0] - p[0] * q[2];
        cr[2] = p[0] * q[1] - p[1] * q[0];
        len = 0;
        for (i = 0; i < 3; i++) begin
            m[i] = cr[i] < 0 ? -cr[i] : cr[i];
            for (k = 67; k >= 0; k--)
                if (m[i][k] && k + 1 > len) len = k + 1;
        end
        if (len == 0) begin
            r = '{x: '0, y: '0, z: '0, degen: 1'b1};
            return r;
        end
        for (i = 0; i < 3; i++)
            s[i] = len > 31 ? 31'(m[i] >> (len - 31)) : 31'(m[i] << (31 - len));
        sum = 64'(s[0]) * s[0] + 64'(s[1]) * s[1] + 64'(s[2]) * s[2];
        root = isqrt(sum);
        for (i = 0; i < 3; i++) begin
            qv = ((64'(s[i]) << 30) + (root >> 1)) / root;
            if (cr[i] < 0) qv = -qv;
            case (i)
                0: r.x = qv[31:0];
                1: r.y = qv[31:0];
                default: r.z = qv[31:0];
            endcase
        end
        r.degen = 1'b0;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        mismatch_cnt++;
    endtask

    // Called at a rising edge; returns at the edge where the request is taken.
    task automatic send_triangle(input t_tri t);
        int gap;
        gap = tx_no_gaps ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_ax <= t[0]; i_ay <= t[1]; i_az <= t[2];
        i_bx <= t[3]; i_by <= t[4]; i_bz <= t[5];
        i_cx <= t[6]; i_cy <= t[7]; i_cz <= t[8];
        @(negedge i_clk);
        while (o_stall) @(negedge i_clk);
        normal_q.push_back(unit_normal(t, winding_cw));
        @(posedge i_clk);
    endtask

    task automatic write_winding(input bit cw);
        // drop the request line first so nothing is taken while draining
        i_valid     <= 1'b0;
        while (normal_q.size() != 0) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= cw;
        @(negedge i_clk);
        while (!o_cfg_ready) @(negedge i_clk);
        @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        winding_cw = cw;
    endtask

    function automatic logic [31:0] extreme_coord();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            4: return 32'h0000_0001;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_tri random_triangle();
        t_tri t;
        logic [31:0] base;
        int i, span;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: for (i = 0; i < 9; i++) t[i] = $urandom;
            4, 5, 6: begin
                span = $urandom_range(1, 24);
                for (i = 0; i < 3; i++) begin
                    base = $urandom;
                    t[i]   = base + ($urandom & ((1 << span) - 1)) - (1 << (span - 1));
                    t[3+i] = base + ($urandom & ((1 << span) - 1)) - (1 << (span - 1));
                    t[6+i] = base + ($urandom & ((1 << span) - 1)) - (1 << (span - 1));
                end
            end
            7: for (i = 0; i < 3; i++) begin
                // collinear points: c continues the edge a to b
                t[i]   = $urandom_range(0, 32'hffff) - 32'h8000;
                t[3+i] = $urandom_range(0, 32'hffff) - 32'h8000;
                t[6+i] = 2 * t[3+i] - t[i];
            end
            8: for (i = 0; i < 9; i++) t[i] = extreme_coord();
            default: begin
                for (i = 0; i < 9; i++) t[i] = $urandom;
                for (i = 0; i < 3; i++) t[3 * $urandom_range(1, 2) + i] = t[i];
            end
        endcase
        return t;
    endfunction

    task automatic test_directed(input bit cw);
        write_winding(cw);
        send_triangle('{default: 32'h0});
        send_triangle('{32'h0, 32'h0, 32'h0, 32'h1_0000, 32'h0, 32'h0,
                        32'h1_0000, 32'h1_0000, 32'h0});
        send_triangle('{32'h0, 32'h0, 32'h0, 32'h0, 32'h1_0000, 32'h0,
                        32'h0, 32'h1_0000, 32'h1_0000});
        send_triangle('{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h1,
                        32'h1, 32'h0, 32'h1});
        send_triangle('{32'h1, 32'h2, 32'h3, 32'h2, 32'h4, 32'h6,
                        32'h3, 32'h6, 32'h9});
        send_triangle('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                        32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
                        32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000});
        send_triangle('{32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                        32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                        32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff});
        send_triangle('{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                        32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                        32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff});
        send_triangle('{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                        32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                        32'h0, 32'h0, 32'h0});
        send_triangle('{32'h0, 32'h0, 32'h0, 32'h1, 32'h1, 32'h0,
                        32'h2, 32'h0, 32'h0});
    endtask

    task automatic test_random(input int count);
        int n;
        for (n = 0; n < count; n++) begin
            if (n % 120 == 60) write_winding($urandom_range(0, 1));
            tx_no_gaps   = (n % 100) >= 80;
            rx_no_stalls = (n % 100) >= 70 && (n % 100) < 90;
            send_triangle(random_triangle());
        end
        tx_no_gaps   = 1'b0;
        rx_no_stalls = 1'b0;
    endtask

    task automatic test_backpressure();
        int n;
        tx_no_gaps = 1'b1;
        long_hold  = 1'b1;
        for (n = 0; n < 120; n++) send_triangle(random_triangle());
        tx_no_gaps = 1'b0;
    endtask

    // Receiver: random stall per request, plus one long hold-off on demand.
    initial begin
        int n;
        forever begin
            if (long_hold) begin
                i_stall <= 1'b1;
                repeat (300) @(posedge i_clk);
                long_hold = 1'b0;
            end
            n = rx_no_stalls ? 0 : $urandom_range(0, 13);
            if (n > 0) begin
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            @(negedge i_clk);
            while (!o_valid) @(negedge i_clk);
            @(posedge i_clk);
        end
    end

    // Outputs are stable at the falling edge; a request seen here is taken at the next rise.
    always @(negedge i_clk) begin
        t_normal want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (normal_q.size() == 0) begin
                $display("unexpected result at %0t", $realtime);
                mismatch_cnt++;
            end else begin
                want = normal_q.pop_front();
                if (o_normal_x !== want.x) report_mismatch("normal_x", o_normal_x, want.x);
                if (o_normal_y !== want.y) report_mismatch("normal_y", o_normal_y, want.y);
                if (o_normal_z !== want.z) report_mismatch("normal_z", o_normal_z, want.z);
                if (o_degenerate !== want.degen)
                    report_mismatch("degenerate", o_degenerate, want.degen);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CycleLimit) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        cycle_cnt    = 0;
        mismatch_cnt = 0;
        winding_cw   = 1'b0;
        tx_no_gaps   = 1'b0;
        rx_no_stalls = 1'b0;
        long_hold    = 1'b0;
        i_rst_n     <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= 1'b0;
        i_valid     <= 1'b0;
        {i_ax, i_ay, i_az, i_bx, i_by, i_bz, i_cx, i_cy, i_cz} <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed(1'b0);
        test_directed(1'b1);
        test_random(250);
        test_backpressure();
        write_winding(1'b0);
        test_random(130);

        i_valid <= 1'b0;
        while (normal_q.size() != 0) @(posedge i_clk);
        repeat (DrainWait) @(posedge i_clk);
        if (mismatch_cnt == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
